### design/assert_macros.svh
// Assertion macros shared by the priority lock design files.
// Included by the modules that check their own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising edge, off during reset.
`define PLWL_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication.
`define PLWL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PLWL_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/plwl_pkg.sv
// Package for the priority lock with wait list: sizes, codes and shared types.
// No dependencies; used by every other design file but assert_macros.svh.
package plwl_pkg;

	localparam int WAIT_DEPTH = 16;
	localparam int ID_BITS    = 8;
	localparam int CNT_BITS   = $clog2(WAIT_DEPTH + 1);

	// Port field widths
	localparam int TASK_BITS   = 8;
	localparam int PRIO_BITS   = 32;
	localparam int STATUS_BITS = 3;
	localparam int WCNT_BITS   = 5;
	localparam int MODE_BITS   = 2;

	// Front-to-back queue
	localparam int Q_DEPTH    = 2;
	localparam int Q_PTR_BITS = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

	typedef enum logic [MODE_BITS-1:0] {
		LM_TIME_PREEMPT  = 2'd0,
		LM_FIXED_PREEMPT = 2'd1,
		LM_TIME_HOLD     = 2'd2,
		LM_FIXED_HOLD    = 2'd3
	} lock_mode_t;

	typedef enum logic {
		CMD_LOCK   = 1'b0,
		CMD_UNLOCK = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_GRANTED   = 3'd0,
		ST_QUEUED    = 3'd1,
		ST_PREEMPTED = 3'd2,
		ST_HANDED    = 3'd3,
		ST_RELEASED  = 3'd4,
		ST_FULL      = 3'd5
	} status_t;

	typedef enum logic {
		BK_FETCH = 1'b0,
		BK_APPLY = 1'b1
	} back_state_t;

	// Classified word handed from front to back
	typedef struct packed {
		cmd_t                 cmd;
		logic [ID_BITS-1:0]   tid;
		logic [PRIO_BITS-1:0] prio;
		logic                 preempt;
	} op_t;

	// Back to wait row
	typedef struct packed {
		logic                 push;
		logic                 pop;
		logic [ID_BITS-1:0]   id;
		logic [PRIO_BITS-1:0] prio;
	} row_cmd_t;

	// Wait row to back
	typedef struct packed {
		logic [CNT_BITS-1:0]  count;
		logic                 full;
		logic [ID_BITS-1:0]   head_id;
		logic [PRIO_BITS-1:0] head_prio;
	} row_stat_t;

endpackage

### design/plwl_ifs.sv
// Channel interfaces of the priority lock: request, response and config write.
// Depends on plwl_pkg for field widths.
interface plwl_req_if;
	logic                           valid;
	logic                           ready;
	logic                           cmd;
	logic [plwl_pkg::TASK_BITS-1:0] task_id;
	logic [plwl_pkg::PRIO_BITS-1:0] fixed_priority;
	logic [plwl_pkg::PRIO_BITS-1:0] arrival_time;

	modport source (output valid, cmd, task_id, fixed_priority, arrival_time, input ready);
	modport sink (input valid, cmd, task_id, fixed_priority, arrival_time, output ready);
endinterface

interface plwl_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [plwl_pkg::STATUS_BITS-1:0] status;
	logic [plwl_pkg::TASK_BITS-1:0]   owner_id;
	logic                             locked;
	logic [plwl_pkg::TASK_BITS-1:0]   paused_id;
	logic [plwl_pkg::WCNT_BITS-1:0]   wait_count;

	modport source (output valid, status, owner_id, locked, paused_id, wait_count, input ready);
	modport sink (input valid, status, owner_id, locked, paused_id, wait_count, output ready);
endinterface

interface plwl_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [plwl_pkg::MODE_BITS-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

### design/plwl_front.sv
// Front part: holds the lock mode, accepts request words and classifies them.
// Depends on plwl_pkg and the channel interfaces in plwl_ifs.sv.
module plwl_front (
	input  logic              clk,
	input  logic              arst_n,
	plwl_cfg_if.sink          cfg,
	plwl_req_if.sink          req,
	output logic              push_valid,
	input  logic              push_ready,
	output plwl_pkg::op_t     push_data
);

	plwl_pkg::lock_mode_t mode_q;
	logic                 time_based;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= plwl_pkg::LM_FIXED_HOLD;
		end else if (cfg.valid) begin
			mode_q <= plwl_pkg::lock_mode_t'(cfg.data);
		end
	end

	assign cfg.ready = 1'b1;

	always_comb begin
		time_based = (mode_q == plwl_pkg::LM_TIME_PREEMPT) ||
			(mode_q == plwl_pkg::LM_TIME_HOLD);
		push_data.cmd     = plwl_pkg::cmd_t'(req.cmd);
		push_data.tid     = plwl_pkg::ID_BITS'(req.task_id);
		push_data.prio    = time_based ? req.arrival_time : req.fixed_priority;
		push_data.preempt = (mode_q == plwl_pkg::LM_TIME_PREEMPT) ||
			(mode_q == plwl_pkg::LM_FIXED_PREEMPT);
	end

	assign push_valid = req.valid;
	assign req.ready  = push_ready;

endmodule

### design/plwl_fifo.sv
// Short queue of classified words between the front and back parts.
// Depends on plwl_pkg for op_t and the queue depth.
module plwl_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  plwl_pkg::op_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output plwl_pkg::op_t pop_data
);

	plwl_pkg::op_t                   ent_q [plwl_pkg::Q_DEPTH];
	logic [plwl_pkg::Q_PTR_BITS-1:0] wr_ptr_q;
	logic [plwl_pkg::Q_PTR_BITS-1:0] rd_ptr_q;
	logic [plwl_pkg::Q_CNT_BITS-1:0] cnt_q;
	logic                            do_push;
	logic                            do_pop;

	assign push_ready = (cnt_q != plwl_pkg::Q_CNT_BITS'(plwl_pkg::Q_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = ent_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == plwl_pkg::Q_PTR_BITS'(plwl_pkg::Q_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == plwl_pkg::Q_PTR_BITS'(plwl_pkg::Q_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### design/plwl_wait_row.sv
// Sorted row of wait cells: insert behind equal priorities, pop from the head.
// Depends on plwl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module plwl_wait_row (
	input  logic                clk,
	input  logic                arst_n,
	input  plwl_pkg::row_cmd_t  cmd,
	output plwl_pkg::row_stat_t stat
);

	localparam int N = plwl_pkg::WAIT_DEPTH;

	logic [plwl_pkg::ID_BITS-1:0]   id_q   [N];
	logic [plwl_pkg::PRIO_BITS-1:0] prio_q [N];
	logic [plwl_pkg::CNT_BITS-1:0]  count_q;

	logic [N-1:0]                   le;
	logic [N-1:0]                   prev_le;
	logic [plwl_pkg::ID_BITS-1:0]   up_id   [N];
	logic [plwl_pkg::PRIO_BITS-1:0] up_prio [N];
	logic [plwl_pkg::ID_BITS-1:0]   dn_id   [N];
	logic [plwl_pkg::PRIO_BITS-1:0] dn_prio [N];

	// le is a prefix mask: cells that stay put on insert
	always_comb begin
		for (int i = 0; i < N; i++) begin
			le[i] = (plwl_pkg::CNT_BITS'(i) < count_q) && (prio_q[i] <= cmd.prio);
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_nbr
		if (i == 0) begin : g_first
			assign prev_le[i] = 1'b1;
			assign up_id[i]   = cmd.id;
			assign up_prio[i] = cmd.prio;
		end else begin : g_rest
			assign prev_le[i] = le[i-1];
			assign up_id[i]   = id_q[i-1];
			assign up_prio[i] = prio_q[i-1];
		end
		if (i == N - 1) begin : g_last
			assign dn_id[i]   = id_q[i];
			assign dn_prio[i] = prio_q[i];
		end else begin : g_inner
			assign dn_id[i]   = id_q[i+1];
			assign dn_prio[i] = prio_q[i+1];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < N; i++) begin
			if (cmd.push && !le[i]) begin
				if (prev_le[i]) begin
					id_q[i]   <= cmd.id;
					prio_q[i] <= cmd.prio;
				end else begin
					id_q[i]   <= up_id[i];
					prio_q[i] <= up_prio[i];
				end
			end else if (cmd.pop) begin
				id_q[i]   <= dn_id[i];
				prio_q[i] <= dn_prio[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.push && !cmd.pop) begin
			count_q <= count_q + 1'b1;
		end else if (cmd.pop && !cmd.push) begin
			count_q <= count_q - 1'b1;
		end
	end

	assign stat.count     = count_q;
	assign stat.full      = (count_q == plwl_pkg::CNT_BITS'(N));
	assign stat.head_id   = id_q[0];
	assign stat.head_prio = prio_q[0];

	`PLWL_ASSERT_IMP(a_row_one_op, clk, arst_n, cmd.push, !cmd.pop, "push and pop together")
	`PLWL_ASSERT(a_row_bound, clk, arst_n, count_q <= plwl_pkg::CNT_BITS'(N), "row overfilled")
	`PLWL_ASSERT_NXT(a_row_grow, clk, arst_n, cmd.push, count_q == $past(count_q) + 1'b1,
		"push did not grow row")

endmodule

### design/plwl_back.sv
// Back part: lock holder state, decision and apply sequencer, result register.
// Depends on plwl_pkg, plwl_wait_row, plwl_rsp_if and assert_macros.svh.
`include "assert_macros.svh"

module plwl_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  plwl_pkg::op_t pop_data,
	plwl_rsp_if.source    rsp
);

	plwl_pkg::back_state_t state_q;
	plwl_pkg::back_state_t state_nxt;

	logic                           lock_held_q;
	logic [plwl_pkg::ID_BITS-1:0]   holder_id_q;
	logic [plwl_pkg::PRIO_BITS-1:0] holder_prio_q;

	// Decision taken in fetch, carried out in apply
	plwl_pkg::status_t              dec_status_q;
	logic                           dec_held_q;
	logic [plwl_pkg::ID_BITS-1:0]   dec_hid_q;
	logic [plwl_pkg::PRIO_BITS-1:0] dec_hprio_q;
	logic                           dec_push_q;
	logic                           dec_pop_q;
	logic [plwl_pkg::ID_BITS-1:0]   dec_ins_id_q;
	logic [plwl_pkg::PRIO_BITS-1:0] dec_ins_prio_q;
	logic [plwl_pkg::ID_BITS-1:0]   dec_paused_q;

	plwl_pkg::status_t              d_status;
	logic                           d_held;
	logic [plwl_pkg::ID_BITS-1:0]   d_hid;
	logic [plwl_pkg::PRIO_BITS-1:0] d_hprio;
	logic                           d_push;
	logic                           d_pop;
	logic [plwl_pkg::ID_BITS-1:0]   d_ins_id;
	logic [plwl_pkg::PRIO_BITS-1:0] d_ins_prio;
	logic [plwl_pkg::ID_BITS-1:0]   d_paused;

	logic                           out_valid_q;
	plwl_pkg::status_t              out_status_q;
	logic [plwl_pkg::TASK_BITS-1:0] out_owner_q;
	logic                           out_locked_q;
	logic [plwl_pkg::TASK_BITS-1:0] out_paused_q;
	logic [plwl_pkg::WCNT_BITS-1:0] out_wcnt_q;

	logic                           out_free;
	logic                           apply_en;
	logic [plwl_pkg::CNT_BITS-1:0]  count_after;
	plwl_pkg::row_cmd_t             row_cmd;
	plwl_pkg::row_stat_t            row_stat;

	plwl_wait_row u_row (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (row_cmd),
		.stat   (row_stat)
	);

	assign out_free = !out_valid_q || rsp.ready;

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			plwl_pkg::BK_FETCH: if (pop_valid) state_nxt = plwl_pkg::BK_APPLY;
			plwl_pkg::BK_APPLY: if (out_free) state_nxt = plwl_pkg::BK_FETCH;
			default:            state_nxt = plwl_pkg::BK_FETCH;
		endcase
	end

	// State outputs
	always_comb begin
		pop_ready = 1'b0;
		apply_en  = 1'b0;
		unique case (state_q)
			plwl_pkg::BK_FETCH: pop_ready = 1'b1;
			plwl_pkg::BK_APPLY: apply_en  = out_free;
			default: begin
				pop_ready = 1'b0;
				apply_en  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= plwl_pkg::BK_FETCH;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Decision against the state left by the previous word
	always_comb begin
		d_status   = plwl_pkg::ST_RELEASED;
		d_held     = lock_held_q;
		d_hid      = holder_id_q;
		d_hprio    = holder_prio_q;
		d_push     = 1'b0;
		d_pop      = 1'b0;
		d_ins_id   = pop_data.tid;
		d_ins_prio = pop_data.prio;
		d_paused   = '0;
		if (pop_data.cmd == plwl_pkg::CMD_LOCK) begin
			if (!lock_held_q) begin
				d_status = plwl_pkg::ST_GRANTED;
				d_held   = 1'b1;
				d_hid    = pop_data.tid;
				d_hprio  = pop_data.prio;
			end else if (row_stat.full) begin
				d_status = plwl_pkg::ST_FULL;
			end else if (pop_data.preempt && (holder_prio_q > pop_data.prio)) begin
				// old holder goes back into the row
				d_status   = plwl_pkg::ST_PREEMPTED;
				d_push     = 1'b1;
				d_ins_id   = holder_id_q;
				d_ins_prio = holder_prio_q;
				d_hid      = pop_data.tid;
				d_hprio    = pop_data.prio;
				d_paused   = holder_id_q;
			end else begin
				d_status = plwl_pkg::ST_QUEUED;
				d_push   = 1'b1;
				d_paused = pop_data.tid;
			end
		end else begin
			if (lock_held_q && (row_stat.count != '0)) begin
				d_status = plwl_pkg::ST_HANDED;
				d_pop    = 1'b1;
				d_hid    = row_stat.head_id;
				d_hprio  = row_stat.head_prio;
			end else begin
				d_status = plwl_pkg::ST_RELEASED;
				d_held   = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			dec_status_q   <= d_status;
			dec_held_q     <= d_held;
			dec_hid_q      <= d_hid;
			dec_hprio_q    <= d_hprio;
			dec_push_q     <= d_push;
			dec_pop_q      <= d_pop;
			dec_ins_id_q   <= d_ins_id;
			dec_ins_prio_q <= d_ins_prio;
			dec_paused_q   <= d_paused;
		end
	end

	always_comb begin
		row_cmd.push = apply_en && dec_push_q;
		row_cmd.pop  = apply_en && dec_pop_q;
		row_cmd.id   = dec_ins_id_q;
		row_cmd.prio = dec_ins_prio_q;
		count_after  = row_stat.count;
		if (dec_push_q) begin
			count_after = row_stat.count + 1'b1;
		end else if (dec_pop_q) begin
			count_after = row_stat.count - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_held_q   <= 1'b0;
			holder_id_q   <= '0;
			holder_prio_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (apply_en) begin
				lock_held_q   <= dec_held_q;
				holder_id_q   <= dec_hid_q;
				holder_prio_q <= dec_hprio_q;
				out_valid_q   <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (apply_en) begin
			out_status_q <= dec_status_q;
			out_owner_q  <= dec_held_q ? plwl_pkg::TASK_BITS'(dec_hid_q) : '0;
			out_locked_q <= dec_held_q;
			out_paused_q <= plwl_pkg::TASK_BITS'(dec_paused_q);
			out_wcnt_q   <= plwl_pkg::WCNT_BITS'(count_after);
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.owner_id   = out_owner_q;
	assign rsp.locked     = out_locked_q;
	assign rsp.paused_id  = out_paused_q;
	assign rsp.wait_count = out_wcnt_q;

	`PLWL_ASSERT_IMP(a_no_push_full, clk, arst_n, row_cmd.push, !row_stat.full,
		"insert into a full row")
	`PLWL_ASSERT_IMP(a_no_pop_empty, clk, arst_n, row_cmd.pop, row_stat.count != '0,
		"pop from an empty row")
	`PLWL_ASSERT_IMP(a_wait_needs_holder, clk, arst_n, row_stat.count != '0, lock_held_q,
		"waiters while the lock is free")

endmodule

### design/priority_lock_with_wait_list.sv
// Top level of the priority lock with wait list.
// Depends on plwl_pkg, plwl_ifs.sv, plwl_front, plwl_fifo and plwl_back.
//
//  channel  dir  modport  word
//  cfg      in   sink     lock_mode (2 bits), taken any cycle
//  req      in   sink     cmd, task_id, fixed_priority, arrival_time
//  rsp      out  source   status, owner_id, locked, paused_id, wait_count
//
// Each word passes the back states fetch/decide and then apply, and the
// back part takes no new word until it has applied the last; apply waits on rsp.
// The front queue holds two words while the back part or rsp stalls.
// Reset clears the lock, the wait count and the mode (fixed nonpreemptive);
// wait cells are not cleared and there is no clearing pass.
module priority_lock_with_wait_list (
	input logic        clk,
	input logic        arst_n,
	plwl_cfg_if.sink   cfg,
	plwl_req_if.sink   req,
	plwl_rsp_if.source rsp
);

	logic          fe_valid;
	logic          fe_ready;
	plwl_pkg::op_t fe_data;
	logic          be_valid;
	logic          be_ready;
	plwl_pkg::op_t be_data;

	plwl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.req        (req),
		.push_valid (fe_valid),
		.push_ready (fe_ready),
		.push_data  (fe_data)
	);

	plwl_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fe_valid),
		.push_ready (fe_ready),
		.push_data  (fe_data),
		.pop_valid  (be_valid),
		.pop_ready  (be_ready),
		.pop_data   (be_data)
	);

	plwl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (be_valid),
		.pop_ready (be_ready),
		.pop_data  (be_data),
		.rsp       (rsp)
	);

endmodule
